/* hw/rtl/hcbd_pkg.sv */
package hcbd_pkg;

  // Default width of the chunk size accumulator and byte counter
  localparam int unsigned SizeBitsDefault = 32;

  // Framing characters
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Decoder phase, one-hot
  typedef enum logic [7:0] {
    PH_SIZE    = 8'b0000_0001,
    PH_DATA    = 8'b0000_0010,
    PH_DATA_CR = 8'b0000_0100,
    PH_DATA_LF = 8'b0000_1000,
    PH_END_CR  = 8'b0001_0000,
    PH_END_LF  = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_e;

  // One result item plus its valid flag
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload;
    logic       chunk_end;
  } result_t;

  // Hex digit decode: {is_digit, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Whitespace skipped ahead of the first size digit
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

/* hw/rtl/hcbd_in_if.sv */
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

/* hw/rtl/hcbd_out_if.sv */
interface hcbd_out_if;
  logic               valid;
  logic               ready;
  hcbd_pkg::kind_e    kind;
  logic [7:0]         payload;
  logic               chunk_end;

  modport source (output valid, output kind, output payload, output chunk_end, input ready);
  modport sink (input valid, input kind, input payload, input chunk_end, output ready);
endinterface

/* hw/rtl/http_chunked_body_decoder.sv */
// Chunked transfer body decoder. Feed the message body one byte per item,
// marking the first body byte with first_byte (which clears all decoder
// state). Payload bytes come out with chunk_end flagging the last byte of
// each chunk; the terminating zero-size chunk yields one done item, and a
// framing fault or a size that overflows SIZE_BITS yields one error item,
// after which the decoder stays silent until the next first byte. One byte
// is accepted every cycle while results are taken: a byte goes through an
// input register, then the combinational state update, into the result
// register, giving one byte per clock when the output does not stall.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);
  import hcbd_pkg::*;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;
  logic       s1_adv;

  // Decoder state
  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic                 saw_digit_q, saw_digit_d;
  logic                 digits_closed_q, digits_closed_d;
  logic                 saw_cr_q, saw_cr_d;
  result_t              res;

  // Result register
  logic       out_valid_q;
  kind_e      out_kind_q;
  logic [7:0] out_payload_q;
  logic       out_chunk_end_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q  <= in_i.data_byte;
      s1_first_q <= in_i.first_byte;
    end
  end

  hcbd_step #(
    .SizeBits(SIZE_BITS)
  ) u_step (
    .data_byte_i    (s1_byte_q),
    .first_byte_i   (s1_first_q),
    .phase_i        (phase_q),
    .acc_i          (acc_q),
    .rem_i          (rem_q),
    .saw_digit_i    (saw_digit_q),
    .digits_closed_i(digits_closed_q),
    .saw_cr_i       (saw_cr_q),
    .phase_o        (phase_d),
    .acc_o          (acc_d),
    .rem_o          (rem_d),
    .saw_digit_o    (saw_digit_d),
    .digits_closed_o(digits_closed_d),
    .saw_cr_o       (saw_cr_d),
    .res_o          (res)
  );

  // State update when a byte leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_SIZE;
      acc_q           <= '0;
      rem_q           <= '0;
      saw_digit_q     <= 1'b0;
      digits_closed_q <= 1'b0;
      saw_cr_q        <= 1'b0;
    end else if (s1_adv) begin
      phase_q         <= phase_d;
      acc_q           <= acc_d;
      rem_q           <= rem_d;
      saw_digit_q     <= saw_digit_d;
      digits_closed_q <= digits_closed_d;
      saw_cr_q        <= saw_cr_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= res.valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res.valid) begin
      out_kind_q      <= res.kind;
      out_payload_q   <= res.payload;
      out_chunk_end_q <= res.chunk_end;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.payload   = out_payload_q;
  assign out_o.chunk_end = out_chunk_end_q;

`ifndef NO_ASSERTIONS
  // chunk_end only ever accompanies a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_chunk_end_q) |-> (out_kind_q == KIND_PAYLOAD))
    else $error("chunk_end set on a non-payload item");

  // In the data phase there is always at least one byte left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("data phase with zero bytes remaining");

  // Input stalls only while a byte is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // Terminal phases produce nothing unless restarted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_first_q && (phase_q == PH_DONE || phase_q == PH_ERROR))
      |=> !out_valid_q)
    else $error("result produced from a terminal phase");
`endif

endmodule

/* hw/rtl/hcbd_step.sv */
module hcbd_step #(
  parameter int unsigned SizeBits = hcbd_pkg::SizeBitsDefault
) (
  input  logic [7:0]           data_byte_i,
  input  logic                 first_byte_i,
  input  hcbd_pkg::phase_e     phase_i,
  input  logic [SizeBits-1:0]  acc_i,
  input  logic [SizeBits-1:0]  rem_i,
  input  logic                 saw_digit_i,
  input  logic                 digits_closed_i,
  input  logic                 saw_cr_i,
  output hcbd_pkg::phase_e     phase_o,
  output logic [SizeBits-1:0]  acc_o,
  output logic [SizeBits-1:0]  rem_o,
  output logic                 saw_digit_o,
  output logic                 digits_closed_o,
  output logic                 saw_cr_o,
  output hcbd_pkg::result_t    res_o
);
  import hcbd_pkg::*;

  localparam logic [SizeBits-1:0] One = {{(SizeBits-1){1'b0}}, 1'b1};

  phase_e              ph;
  logic [SizeBits-1:0] acc;
  logic [SizeBits-1:0] rem;
  logic [SizeBits-1:0] rem_dec;
  logic                sd;
  logic                dc;
  logic                scr;
  logic [4:0]          hv;

  // A first byte starts from the cleared state
  always_comb begin
    ph  = first_byte_i ? PH_SIZE : phase_i;
    acc = first_byte_i ? '0 : acc_i;
    rem = first_byte_i ? '0 : rem_i;
    sd  = first_byte_i ? 1'b0 : saw_digit_i;
    dc  = first_byte_i ? 1'b0 : digits_closed_i;
    scr = first_byte_i ? 1'b0 : saw_cr_i;
  end

  assign hv      = hex_value(data_byte_i);
  assign rem_dec = rem - One;

  // Per-byte state update and result
  always_comb begin
    phase_o         = ph;
    acc_o           = acc;
    rem_o           = rem;
    saw_digit_o     = sd;
    digits_closed_o = dc;
    saw_cr_o        = scr;
    res_o           = '{valid: 1'b0, kind: KIND_PAYLOAD, payload: 8'd0, chunk_end: 1'b0};

    unique case (ph)
      PH_SIZE: begin
        if (scr && data_byte_i == ChLf) begin
          // CR LF closes the size line
          acc_o           = '0;
          saw_digit_o     = 1'b0;
          digits_closed_o = 1'b0;
          saw_cr_o        = 1'b0;
          if (!sd || acc == '0) begin
            phase_o = PH_END_CR;
          end else begin
            rem_o   = acc;
            phase_o = PH_DATA;
          end
        end else begin
          saw_cr_o = (data_byte_i == ChCr);
          if (!dc) begin
            if (hv[4]) begin
              if (acc[SizeBits-1 -: 4] != 4'd0) begin
                // digit would shift set bits out
                phase_o = PH_ERROR;
                res_o   = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, chunk_end: 1'b0};
              end else begin
                acc_o       = {acc[SizeBits-5:0], hv[3:0]};
                saw_digit_o = 1'b1;
              end
            end else if (sd || !is_space(data_byte_i)) begin
              digits_closed_o = 1'b1;
            end
          end
        end
      end

      PH_DATA: begin
        rem_o = rem_dec;
        res_o = '{valid: 1'b1, kind: KIND_PAYLOAD, payload: data_byte_i,
                  chunk_end: (rem_dec == '0)};
        if (rem_dec == '0) begin
          phase_o = PH_DATA_CR;
        end
      end

      PH_DATA_CR, PH_END_CR: begin
        if (data_byte_i != ChCr) begin
          phase_o = PH_ERROR;
          res_o   = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, chunk_end: 1'b0};
        end else begin
          phase_o = (ph == PH_DATA_CR) ? PH_DATA_LF : PH_END_LF;
        end
      end

      PH_DATA_LF: begin
        if (data_byte_i != ChLf) begin
          phase_o = PH_ERROR;
          res_o   = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, chunk_end: 1'b0};
        end else begin
          phase_o         = PH_SIZE;
          acc_o           = '0;
          saw_digit_o     = 1'b0;
          digits_closed_o = 1'b0;
          saw_cr_o        = 1'b0;
        end
      end

      PH_END_LF: begin
        if (data_byte_i != ChLf) begin
          phase_o = PH_ERROR;
          res_o   = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, chunk_end: 1'b0};
        end else begin
          phase_o = PH_DONE;
          res_o   = '{valid: 1'b1, kind: KIND_DONE, payload: 8'd0, chunk_end: 1'b0};
        end
      end

      PH_DONE, PH_ERROR: begin
        // terminal until the next first byte
      end

      default: begin
        phase_o = PH_ERROR;
      end
    endcase
  end

endmodule
